// ----- src/tlvd_pkg.sv -----
// Shared types and constants for the TLV channel demux with HID report queue.
// Used by tlv_channel_demux_hid_queue_core, tlvd_checker and testbench; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tlvd_pkg;

    localparam int HID_DEPTH_DEF  = 81;
    localparam int PIPE_DEPTH_DEF = 256;

    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 2;

    localparam logic [CFG_IDX_W-1:0] REG_HID_CODE      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PIPE_CODE     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_JIGGLE_ENABLE = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_JIGGLE_PERIOD = 2'd3;

    localparam logic [7:0]  HID_CODE_RST      = 8'd1;
    localparam logic [7:0]  PIPE_CODE_RST     = 8'd2;
    localparam logic [15:0] JIGGLE_PERIOD_RST = 16'd5000;

    localparam logic [7:0] LEN_MOUSE    = 8'd2;
    localparam logic [7:0] LEN_KEYBOARD = 8'd7;
    localparam logic [7:0] LEN_WIDE     = 8'd4;
    localparam logic [7:0] REPORT_LEN   = 8'd7;

    localparam logic [7:0] RPT_TYPE_1   = 8'd1;
    localparam logic [7:0] RPT_TYPE_2   = 8'd2;
    localparam logic [7:0] JIGGLE_PLUS  = 8'h01;
    localparam logic [7:0] JIGGLE_MINUS = 8'hFF;

    localparam int REPORT_BYTES = 8;
    localparam int REPORT_W     = 8 * REPORT_BYTES;

    typedef enum logic [1:0] {
        KIND_BYTE      = 2'd0,
        KIND_TICK      = 2'd1,
        KIND_PULL_HID  = 2'd2,
        KIND_PULL_PIPE = 2'd3
    } kind_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] rx_byte;
        logic       rx_idle;
    } item_t;

    typedef struct packed {
        logic       accepted;
        logic [7:0] rpt_type;
        logic [7:0] report_byte_0;
        logic [7:0] report_byte_1;
        logic [7:0] report_byte_2;
        logic [7:0] report_byte_3;
        logic [7:0] report_byte_4;
        logic [7:0] report_byte_5;
        logic [7:0] report_byte_6;
        logic [7:0] pipe_out_byte;
        logic       pipe_out_valid;
        logic       send_resume;
    } result_t;

endpackage

`default_nettype wire

// ----- src/tlvd_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module tlvd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ----- src/tlv_channel_demux_hid_queue_core.sv -----
// Top level: TLV frame parser, HID report ring, pipe ring, tick handling.
// Depends on tlvd_pkg and tlvd_ram.
//
//   port group   | dir | beat contents
//   item_*       | in  | item_t: kind, rx_byte, rx_idle
//   result_*     | out | result_t: one result per item
//   cfg_*        | in  | register write, index and data, no handshake
//
// Simple items (channel/length/data byte, tick, empty pull) go from S_IDLE to S_DONE.
// A final HID data byte passes through S_PUSH for its pad bytes (up to 7); a jiggle
// pushes its 8 report bytes there. An HID pull makes 8 reads through the one HID ring
// read port in S_HID_RD. A pipe pull reads the ring in S_PIPE_RD. Reset clears control state
// only; ring contents are not cleared. A stalled result blocks the next
// item from finishing but not from being accepted.
`timescale 1ns / 1ps
`default_nettype none

module tlv_channel_demux_hid_queue_core #(
    parameter int HID_DEPTH  = tlvd_pkg::HID_DEPTH_DEF,
    parameter int PIPE_DEPTH = tlvd_pkg::PIPE_DEPTH_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           item_valid,
    output logic                                item_ready,
    input  wire tlvd_pkg::item_t                item,
    output logic                                result_valid,
    input  wire logic                           result_ready,
    output tlvd_pkg::result_t                   result,
    input  wire logic                           cfg_we,
    input  wire logic [tlvd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [tlvd_pkg::CFG_DATA_W-1:0] cfg_data
);

    import tlvd_pkg::*;

    localparam int HID_AW  = $clog2(HID_DEPTH);
    localparam int HID_FW  = $clog2(HID_DEPTH + 1);
    localparam int PIPE_AW = $clog2(PIPE_DEPTH);
    localparam int PIPE_FW = $clog2(PIPE_DEPTH + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_PUSH,
        S_HID_RD,
        S_PIPE_RD,
        S_DONE
    } state_t;

    typedef enum logic [1:0] {
        PH_CHAN   = 2'd0,
        PH_LENGTH = 2'd1,
        PH_DATA   = 2'd2
    } phase_t;

    // configuration
    logic [7:0]  hid_code_reg;
    logic [7:0]  pipe_code_reg;
    logic        jiggle_en_reg;
    logic [15:0] jiggle_period_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hid_code_reg      <= HID_CODE_RST;
            pipe_code_reg     <= PIPE_CODE_RST;
            jiggle_en_reg     <= 1'b1;
            jiggle_period_reg <= JIGGLE_PERIOD_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_HID_CODE:      hid_code_reg      <= cfg_data[7:0];
                REG_PIPE_CODE:     pipe_code_reg     <= cfg_data[7:0];
                REG_JIGGLE_ENABLE: jiggle_en_reg     <= cfg_data[0];
                REG_JIGGLE_PERIOD: jiggle_period_reg <= cfg_data[15:0];
            endcase
        end
    end

    // state registers
    state_t              state_reg, state_next;
    phase_t              phase_reg, phase_next;
    logic [7:0]          chan_reg, chan_next;
    logic [7:0]          length_reg, length_next;
    logic [7:0]          seen_reg, seen_next;
    logic                resume_pend_reg, resume_pend_next;
    logic [15:0]         jiggle_left_reg, jiggle_left_next;
    logic                jiggle_neg_reg, jiggle_neg_next;
    logic [HID_AW-1:0]   hid_rd_ptr_reg, hid_rd_ptr_next;
    logic [HID_AW-1:0]   hid_wr_ptr_reg, hid_wr_ptr_next;
    logic [HID_FW-1:0]   hid_fill_reg, hid_fill_next;
    logic [PIPE_AW-1:0]  pipe_rd_ptr_reg, pipe_rd_ptr_next;
    logic [PIPE_AW-1:0]  pipe_wr_ptr_reg, pipe_wr_ptr_next;
    logic [PIPE_FW-1:0]  pipe_fill_reg, pipe_fill_next;
    logic [3:0]          push_left_reg, push_left_next;
    logic [2:0]          push_idx_reg, push_idx_next;
    logic                push_jig_reg, push_jig_next;
    logic [2:0]          rd_cnt_reg, rd_cnt_next;
    logic                acc_reg, acc_next;
    logic                resume_reg, resume_next;
    logic [REPORT_W-1:0] report_reg, report_next;
    logic [7:0]          pipe_byte_reg, pipe_byte_next;
    logic                pipe_valid_reg, pipe_valid_next;
    logic                result_valid_reg, result_valid_next;
    result_t             result_reg, result_next;

    // memory ports
    logic               hid_we, hid_re;
    logic [7:0]         hid_wd, hid_rd_data;
    logic               pipe_we, pipe_re;
    logic [7:0]         pipe_rd_data;
    logic               hid_push;
    logic [7:0]         hid_push_data;

    logic               hid_full, pipe_full, is_hid, is_pipe;
    logic [7:0]         seen_inc;
    logic [15:0]        left_dec;
    logic [HID_AW-1:0]  hid_rd_ptr_inc, hid_wr_ptr_inc;
    logic [PIPE_AW-1:0] pipe_rd_ptr_inc, pipe_wr_ptr_inc;

    assign hid_full  = (hid_fill_reg == HID_FW'(HID_DEPTH));
    assign pipe_full = (pipe_fill_reg == PIPE_FW'(PIPE_DEPTH));
    assign is_hid    = (chan_reg == hid_code_reg);
    assign is_pipe   = !is_hid && (chan_reg == pipe_code_reg);
    assign seen_inc  = seen_reg + 8'd1;
    assign left_dec  = jiggle_left_reg - 16'd1;

    assign hid_rd_ptr_inc  = (hid_rd_ptr_reg == HID_AW'(HID_DEPTH - 1)) ? '0
                                                                         : hid_rd_ptr_reg + 1'b1;
    assign hid_wr_ptr_inc  = (hid_wr_ptr_reg == HID_AW'(HID_DEPTH - 1)) ? '0
                                                                         : hid_wr_ptr_reg + 1'b1;
    assign pipe_rd_ptr_inc = (pipe_rd_ptr_reg == PIPE_AW'(PIPE_DEPTH - 1)) ? '0
                                                                            : pipe_rd_ptr_reg + 1'b1;
    assign pipe_wr_ptr_inc = (pipe_wr_ptr_reg == PIPE_AW'(PIPE_DEPTH - 1)) ? '0
                                                                            : pipe_wr_ptr_reg + 1'b1;

    assign item_ready   = (state_reg == S_IDLE);
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    always_comb
    begin
        state_next        = state_reg;
        phase_next        = phase_reg;
        chan_next         = chan_reg;
        length_next       = length_reg;
        seen_next         = seen_reg;
        resume_pend_next  = resume_pend_reg;
        jiggle_left_next  = jiggle_left_reg;
        jiggle_neg_next   = jiggle_neg_reg;
        hid_rd_ptr_next   = hid_rd_ptr_reg;
        hid_wr_ptr_next   = hid_wr_ptr_reg;
        hid_fill_next     = hid_fill_reg;
        pipe_rd_ptr_next  = pipe_rd_ptr_reg;
        pipe_wr_ptr_next  = pipe_wr_ptr_reg;
        pipe_fill_next    = pipe_fill_reg;
        push_left_next    = push_left_reg;
        push_idx_next     = push_idx_reg;
        push_jig_next     = push_jig_reg;
        rd_cnt_next       = rd_cnt_reg;
        acc_next          = acc_reg;
        resume_next       = resume_reg;
        report_next       = report_reg;
        pipe_byte_next    = pipe_byte_reg;
        pipe_valid_next   = pipe_valid_reg;
        result_valid_next = result_valid_reg && !result_ready;
        result_next       = result_reg;
        hid_re            = 1'b0;
        pipe_re           = 1'b0;
        pipe_we           = 1'b0;
        hid_push          = 1'b0;
        hid_push_data     = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    state_next      = S_DONE;
                    acc_next        = 1'b1;
                    resume_next     = 1'b0;
                    report_next     = '0;
                    pipe_byte_next  = '0;
                    pipe_valid_next = 1'b0;
                    unique case (item.kind)
                        KIND_BYTE:
                        begin
                            unique case (phase_reg)
                                PH_LENGTH:
                                begin
                                    length_next = item.rx_byte;
                                    seen_next   = '0;
                                    phase_next  = PH_DATA;
                                    if (is_hid)
                                    begin
                                        if (item.rx_byte == LEN_MOUSE ||
                                            item.rx_byte == LEN_KEYBOARD)
                                        begin
                                            hid_push      = 1'b1;
                                            hid_push_data = RPT_TYPE_1;
                                        end
                                        else if (item.rx_byte == LEN_WIDE)
                                        begin
                                            hid_push      = 1'b1;
                                            hid_push_data = RPT_TYPE_2;
                                        end
                                    end
                                end
                                PH_DATA:
                                begin
                                    if ((is_hid && hid_full) || (is_pipe && pipe_full))
                                    begin
                                        acc_next = 1'b0;
                                    end
                                    else
                                    begin
                                        if (is_hid)
                                        begin
                                            hid_push      = 1'b1;
                                            hid_push_data = item.rx_byte;
                                        end
                                        if (is_pipe)
                                        begin
                                            pipe_we          = 1'b1;
                                            pipe_wr_ptr_next = pipe_wr_ptr_inc;
                                            pipe_fill_next   = pipe_fill_reg + 1'b1;
                                        end
                                        seen_next = seen_inc;
                                        if (seen_inc == length_reg)
                                        begin
                                            phase_next       = PH_CHAN;
                                            resume_pend_next = 1'b1;
                                            if (is_hid && length_reg < REPORT_LEN)
                                            begin
                                                push_left_next = 4'(REPORT_LEN - length_reg);
                                                push_idx_next  = '0;
                                                push_jig_next  = 1'b0;
                                                state_next     = S_PUSH;
                                            end
                                        end
                                    end
                                end
                                default:
                                begin
                                    chan_next  = item.rx_byte;
                                    phase_next = PH_LENGTH;
                                end
                            endcase
                        end
                        KIND_TICK:
                        begin
                            if (resume_pend_reg && item.rx_idle)
                            begin
                                resume_next      = 1'b1;
                                resume_pend_next = 1'b0;
                            end
                            if (jiggle_en_reg)
                            begin
                                jiggle_left_next = left_dec;
                                if (left_dec == '0)
                                begin
                                    jiggle_left_next = jiggle_period_reg;
                                    if (hid_fill_reg < HID_FW'(HID_DEPTH - 7))
                                    begin
                                        push_left_next = 4'(REPORT_BYTES);
                                        push_idx_next  = '0;
                                        push_jig_next  = 1'b1;
                                        state_next     = S_PUSH;
                                    end
                                end
                            end
                        end
                        KIND_PULL_HID:
                        begin
                            if (hid_fill_reg >= HID_FW'(REPORT_BYTES))
                            begin
                                hid_re          = 1'b1;
                                hid_rd_ptr_next = hid_rd_ptr_inc;
                                rd_cnt_next     = '0;
                                state_next      = S_HID_RD;
                            end
                        end
                        KIND_PULL_PIPE:
                        begin
                            if (pipe_fill_reg != '0)
                            begin
                                pipe_re          = 1'b1;
                                pipe_rd_ptr_next = pipe_rd_ptr_inc;
                                pipe_fill_next   = pipe_fill_reg - 1'b1;
                                state_next       = S_PIPE_RD;
                            end
                        end
                    endcase
                end
            end
            S_PUSH:
            begin
                hid_push = 1'b1;
                if (push_jig_reg)
                begin
                    if (push_idx_reg == 3'd0)
                    begin
                        hid_push_data = RPT_TYPE_2;
                    end
                    else if (push_idx_reg == 3'd2)
                    begin
                        hid_push_data = jiggle_neg_reg ? JIGGLE_MINUS : JIGGLE_PLUS;
                    end
                end
                push_idx_next  = push_idx_reg + 1'b1;
                push_left_next = push_left_reg - 1'b1;
                if (push_left_reg == 4'd1)
                begin
                    state_next = S_DONE;
                    if (push_jig_reg)
                    begin
                        jiggle_neg_next = !jiggle_neg_reg;
                    end
                end
            end
            S_HID_RD:
            begin
                report_next = {report_reg[REPORT_W-9:0], hid_rd_data};
                if (rd_cnt_reg == 3'(REPORT_BYTES - 1))
                begin
                    hid_fill_next = hid_fill_reg - HID_FW'(REPORT_BYTES);
                    state_next    = S_DONE;
                end
                else
                begin
                    hid_re          = 1'b1;
                    hid_rd_ptr_next = hid_rd_ptr_inc;
                    rd_cnt_next     = rd_cnt_reg + 1'b1;
                end
            end
            S_PIPE_RD:
            begin
                pipe_byte_next  = pipe_rd_data;
                pipe_valid_next = 1'b1;
                state_next      = S_DONE;
            end
            S_DONE:
            begin
                if (!result_valid_reg || result_ready)
                begin
                    result_valid_next          = 1'b1;
                    result_next.accepted       = acc_reg;
                    result_next.rpt_type       = report_reg[63:56];
                    result_next.report_byte_0  = report_reg[55:48];
                    result_next.report_byte_1  = report_reg[47:40];
                    result_next.report_byte_2  = report_reg[39:32];
                    result_next.report_byte_3  = report_reg[31:24];
                    result_next.report_byte_4  = report_reg[23:16];
                    result_next.report_byte_5  = report_reg[15:8];
                    result_next.report_byte_6  = report_reg[7:0];
                    result_next.pipe_out_byte  = pipe_byte_reg;
                    result_next.pipe_out_valid = pipe_valid_reg;
                    result_next.send_resume    = resume_reg;
                    state_next                 = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // drop the byte when the HID ring is full
        hid_we = hid_push && !hid_full;
        hid_wd = hid_push_data;
        if (hid_we)
        begin
            hid_wr_ptr_next = hid_wr_ptr_inc;
            hid_fill_next   = hid_fill_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            phase_reg        <= PH_CHAN;
            chan_reg         <= '0;
            length_reg       <= '0;
            seen_reg         <= '0;
            resume_pend_reg  <= 1'b0;
            jiggle_left_reg  <= JIGGLE_PERIOD_RST;
            jiggle_neg_reg   <= 1'b0;
            hid_rd_ptr_reg   <= '0;
            hid_wr_ptr_reg   <= '0;
            hid_fill_reg     <= '0;
            pipe_rd_ptr_reg  <= '0;
            pipe_wr_ptr_reg  <= '0;
            pipe_fill_reg    <= '0;
            push_left_reg    <= '0;
            push_idx_reg     <= '0;
            push_jig_reg     <= 1'b0;
            rd_cnt_reg       <= '0;
            acc_reg          <= 1'b0;
            resume_reg       <= 1'b0;
            report_reg       <= '0;
            pipe_byte_reg    <= '0;
            pipe_valid_reg   <= 1'b0;
            result_valid_reg <= 1'b0;
            result_reg       <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            phase_reg        <= phase_next;
            chan_reg         <= chan_next;
            length_reg       <= length_next;
            seen_reg         <= seen_next;
            resume_pend_reg  <= resume_pend_next;
            jiggle_left_reg  <= jiggle_left_next;
            jiggle_neg_reg   <= jiggle_neg_next;
            hid_rd_ptr_reg   <= hid_rd_ptr_next;
            hid_wr_ptr_reg   <= hid_wr_ptr_next;
            hid_fill_reg     <= hid_fill_next;
            pipe_rd_ptr_reg  <= pipe_rd_ptr_next;
            pipe_wr_ptr_reg  <= pipe_wr_ptr_next;
            pipe_fill_reg    <= pipe_fill_next;
            push_left_reg    <= push_left_next;
            push_idx_reg     <= push_idx_next;
            push_jig_reg     <= push_jig_next;
            rd_cnt_reg       <= rd_cnt_next;
            acc_reg          <= acc_next;
            resume_reg       <= resume_next;
            report_reg       <= report_next;
            pipe_byte_reg    <= pipe_byte_next;
            pipe_valid_reg   <= pipe_valid_next;
            result_valid_reg <= result_valid_next;
            result_reg       <= result_next;
        end
    end

    tlvd_ram #(
        .WIDTH (8),
        .DEPTH (HID_DEPTH)
    ) u_hid_ram (
        .clk     (clk),
        .wr_en   (hid_we),
        .wr_addr (hid_wr_ptr_reg),
        .wr_data (hid_wd),
        .rd_en   (hid_re),
        .rd_addr (hid_rd_ptr_reg),
        .rd_data (hid_rd_data)
    );

    tlvd_ram #(
        .WIDTH (8),
        .DEPTH (PIPE_DEPTH)
    ) u_pipe_ram (
        .clk     (clk),
        .wr_en   (pipe_we),
        .wr_addr (pipe_wr_ptr_reg),
        .wr_data (item.rx_byte),
        .rd_en   (pipe_re),
        .rd_addr (pipe_rd_ptr_reg),
        .rd_data (pipe_rd_data)
    );

    a_hid_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        hid_fill_reg <= HID_FW'(HID_DEPTH))
        else $error("HID ring fill beyond depth");

    a_pipe_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pipe_fill_reg <= PIPE_FW'(PIPE_DEPTH))
        else $error("pipe ring fill beyond depth");

    a_jiggle_room: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PUSH && push_jig_reg) |-> !hid_full)
        else $error("jiggle report started without room");

    a_report_pop: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_HID_RD && rd_cnt_reg == 3'(REPORT_BYTES - 1))
        |=> hid_fill_reg == $past(hid_fill_reg) - HID_FW'(REPORT_BYTES))
        else $error("HID report pop did not release eight entries");

endmodule

`default_nettype wire

// ----- verif/tlvd_checker.sv -----
// Checker for tlv_channel_demux_hid_queue_core: watches the item, result and register ports,
// predicts each result beat from its own copy of the parser and rings, and compares.
// Depends on tlvd_pkg.
`timescale 1ns / 1ps

module tlvd_checker
    import tlvd_pkg::*;
#(
    parameter int HID_DEPTH  = HID_DEPTH_DEF,
    parameter int PIPE_DEPTH = PIPE_DEPTH_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  item_valid,
    input  logic                  item_ready,
    input  item_t                 item,
    input  logic                  result_valid,
    input  logic                  result_ready,
    input  result_t               result,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    mismatches,
    output int                    outstanding
);

    typedef enum logic [1:0] {
        PH_CHANNEL = 2'd0,
        PH_LENGTH  = 2'd1,
        PH_DATA    = 2'd2
    } parse_phase_t;

    logic [7:0]   hid_code;
    logic [7:0]   pipe_code;
    logic         jiggle_on;
    logic [15:0]  jiggle_period;

    parse_phase_t parse_phase;
    logic [7:0]   frame_chan;
    logic [7:0]   frame_len;
    logic [7:0]   data_count;
    logic         resume_flag;
    logic [15:0]  jiggle_left;
    logic         jiggle_minus;
    logic [7:0]   hid_bytes[$];
    logic [7:0]   pipe_bytes[$];
    result_t      due_results[$];

    function automatic void hid_push(logic [7:0] value);
        if (hid_bytes.size() < HID_DEPTH)
        begin
            hid_bytes.push_back(value);
        end
    endfunction

    function automatic result_t demux_item(item_t it);
        result_t r;
        logic    is_hid;
        logic    is_pipe;
        int      pad;
        r = '0;
        r.accepted = 1'b1;
        case (it.kind)
            KIND_BYTE:
            begin
                if (parse_phase == PH_LENGTH)
                begin
                    frame_len = it.rx_byte;
                    data_count = 8'd0;
                    parse_phase = PH_DATA;
                    if (frame_chan == hid_code)
                    begin
                        if (it.rx_byte == LEN_MOUSE || it.rx_byte == LEN_KEYBOARD)
                        begin
                            hid_push(RPT_TYPE_1);
                        end
                        else if (it.rx_byte == LEN_WIDE)
                        begin
                            hid_push(RPT_TYPE_2);
                        end
                    end
                end
                else if (parse_phase != PH_DATA)
                begin
                    frame_chan = it.rx_byte;
                    parse_phase = PH_LENGTH;
                end
                else
                begin
                    is_hid = (frame_chan == hid_code);
                    is_pipe = !is_hid && (frame_chan == pipe_code);
                    if (is_hid && hid_bytes.size() >= HID_DEPTH)
                    begin
                        r.accepted = 1'b0;
                    end
                    else if (is_pipe && pipe_bytes.size() >= PIPE_DEPTH)
                    begin
                        r.accepted = 1'b0;
                    end
                    else
                    begin
                        if (is_hid)
                        begin
                            hid_push(it.rx_byte);
                        end
                        else if (is_pipe)
                        begin
                            pipe_bytes.push_back(it.rx_byte);
                        end
                        data_count = data_count + 8'd1;
                        if (data_count == frame_len)
                        begin
                            parse_phase = PH_CHANNEL;
                            if (is_hid && frame_len < REPORT_LEN)
                            begin
                                for (pad = int'(frame_len); pad < int'(REPORT_LEN); pad++)
                                begin
                                    hid_push(8'h00);
                                end
                            end
                            resume_flag = 1'b1;
                        end
                    end
                end
            end
            KIND_TICK:
            begin
                if (resume_flag && it.rx_idle)
                begin
                    r.send_resume = 1'b1;
                    resume_flag = 1'b0;
                end
                if (jiggle_on)
                begin
                    jiggle_left = jiggle_left - 16'd1;
                    if (jiggle_left == 16'd0)
                    begin
                        if (HID_DEPTH - hid_bytes.size() > 7)
                        begin
                            hid_push(RPT_TYPE_2);
                            hid_push(8'h00);
                            hid_push(jiggle_minus ? JIGGLE_MINUS : JIGGLE_PLUS);
                            for (pad = 0; pad < 5; pad++)
                            begin
                                hid_push(8'h00);
                            end
                            jiggle_minus = !jiggle_minus;
                        end
                        jiggle_left = jiggle_period;
                    end
                end
            end
            KIND_PULL_HID:
            begin
                if (hid_bytes.size() >= REPORT_BYTES)
                begin
                    r.rpt_type      = hid_bytes.pop_front();
                    r.report_byte_0 = hid_bytes.pop_front();
                    r.report_byte_1 = hid_bytes.pop_front();
                    r.report_byte_2 = hid_bytes.pop_front();
                    r.report_byte_3 = hid_bytes.pop_front();
                    r.report_byte_4 = hid_bytes.pop_front();
                    r.report_byte_5 = hid_bytes.pop_front();
                    r.report_byte_6 = hid_bytes.pop_front();
                end
            end
            default:
            begin
                if (pipe_bytes.size() > 0)
                begin
                    r.pipe_out_byte = pipe_bytes.pop_front();
                    r.pipe_out_valid = 1'b1;
                end
            end
        endcase
        return r;
    endfunction

    function automatic void check_field(string field, int unsigned want, int unsigned got);
        if (want != got)
        begin
            $display("%0t: %s expected %0h actual %0h", $time, field, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        if (!rst_n)
        begin
            hid_code = HID_CODE_RST;
            pipe_code = PIPE_CODE_RST;
            jiggle_on = 1'b1;
            jiggle_period = JIGGLE_PERIOD_RST;
            parse_phase = PH_CHANNEL;
            frame_chan = 8'd0;
            frame_len = 8'd0;
            data_count = 8'd0;
            resume_flag = 1'b0;
            jiggle_left = JIGGLE_PERIOD_RST;
            jiggle_minus = 1'b0;
            hid_bytes.delete();
            pipe_bytes.delete();
            due_results.delete();
            mismatches = 0;
            outstanding = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_HID_CODE:      hid_code = cfg_data[7:0];
                    REG_PIPE_CODE:     pipe_code = cfg_data[7:0];
                    REG_JIGGLE_ENABLE: jiggle_on = cfg_data[0];
                    default:           jiggle_period = cfg_data[15:0];
                endcase
            end
            if (result_valid && result_ready)
            begin
                if (due_results.size() == 0)
                begin
                    $display("%0t: result beat with nothing expected, actual %h", $time, result);
                    mismatches++;
                end
                else
                begin
                    want = due_results.pop_front();
                    check_field("accepted", want.accepted, result.accepted);
                    check_field("rpt_type", want.rpt_type, result.rpt_type);
                    check_field("report_byte_0", want.report_byte_0, result.report_byte_0);
                    check_field("report_byte_1", want.report_byte_1, result.report_byte_1);
                    check_field("report_byte_2", want.report_byte_2, result.report_byte_2);
                    check_field("report_byte_3", want.report_byte_3, result.report_byte_3);
                    check_field("report_byte_4", want.report_byte_4, result.report_byte_4);
                    check_field("report_byte_5", want.report_byte_5, result.report_byte_5);
                    check_field("report_byte_6", want.report_byte_6, result.report_byte_6);
                    check_field("pipe_out_byte", want.pipe_out_byte, result.pipe_out_byte);
                    check_field("pipe_out_valid", want.pipe_out_valid, result.pipe_out_valid);
                    check_field("send_resume", want.send_resume, result.send_resume);
                end
            end
            if (item_valid && item_ready)
            begin
                due_results.push_back(demux_item(item));
            end
            outstanding = due_results.size();
        end
    end

endmodule

// ----- verif/testbench.sv -----
// Top of the testbench for tlv_channel_demux_hid_queue_core: clock, reset, register writes,
// framed byte traffic with ticks and pulls, random stalls, and the final verdict.
// Depends on tlvd_pkg, tlv_channel_demux_hid_queue_core and tlvd_checker.
`timescale 1ns / 1ps

module testbench;
    import tlvd_pkg::*;

    localparam int LIMIT_CYCLES = 1_500_000;

    logic                  clk;
    logic                  rst_n;
    logic                  item_valid;
    logic                  item_ready;
    item_t                 item;
    logic                  result_valid;
    logic                  result_ready;
    result_t               result;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    int                    mismatches;
    int                    outstanding;

    int                    send_gap_max;
    int                    stall_max;
    int                    beats_sent;
    int                    cycles = 0;
    logic [7:0]            hid_chan;
    logic [7:0]            pipe_chan;

    tlv_channel_demux_hid_queue_core u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    tlvd_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .mismatches   (mismatches),
        .outstanding  (outstanding)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT_CYCLES)
        begin
            $display("tlv_channel_demux_hid_queue_core: mismatch");
            $finish;
        end
    end

    // hold off each result beat for a random number of cycles
    initial
    begin
        int   stall_left;
        logic took;
        stall_left = 0;
        result_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            took = result_valid && result_ready;
            @(negedge clk);
            if (took)
            begin
                stall_left = $urandom_range(0, stall_max);
            end
            if (stall_left > 0)
            begin
                result_ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                result_ready <= 1'b1;
            end
        end
    end

    task automatic send_beat(input kind_t k, input logic [7:0] b, input logic idle);
        item_t beat;
        int    gap;
        gap = $urandom_range(0, send_gap_max);
        beat.kind = k;
        beat.rx_byte = b;
        beat.rx_idle = idle;
        repeat (gap)
        begin
            @(negedge clk);
            item_valid <= 1'b0;
        end
        @(negedge clk);
        item_valid <= 1'b1;
        item <= beat;
        do
        begin
            @(posedge clk);
        end
        while (!item_ready);
        beats_sent++;
    endtask

    task automatic wait_drain();
        @(negedge clk);
        item_valid <= 1'b0;
        while (outstanding != 0)
        begin
            @(negedge clk);
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic mix_in(input int pull_pct, input int tick_pct);
        int dice;
        dice = $urandom_range(0, 99);
        if (dice < pull_pct)
        begin
            send_beat($urandom_range(0, 1) ? KIND_PULL_HID : KIND_PULL_PIPE,
                      8'($urandom), 1'($urandom));
        end
        else if (dice < pull_pct + tick_pct)
        begin
            send_beat(KIND_TICK, 8'($urandom), 1'($urandom));
        end
    endtask

    task automatic run_traffic(input int count, input int pull_pct, input int tick_pct,
                               input int long_pct);
        int         start;
        int         len;
        int         dice;
        logic [7:0] chan;
        start = beats_sent;
        while (beats_sent - start < count)
        begin
            dice = $urandom_range(0, 99);
            if (dice < 8)
            begin
                send_beat(kind_t'($urandom_range(0, 3)), 8'($urandom), 1'($urandom));
            end
            else
            begin
                dice = $urandom_range(0, 99);
                if (dice < 45)
                begin
                    chan = hid_chan;
                end
                else if (dice < 80)
                begin
                    chan = pipe_chan;
                end
                else
                begin
                    chan = 8'($urandom);
                end
                if ($urandom_range(0, 99) < long_pct)
                begin
                    len = 0;
                end
                else if (chan == hid_chan && $urandom_range(0, 9) < 6)
                begin
                    case ($urandom_range(0, 2))
                        0:       len = int'(LEN_MOUSE);
                        1:       len = int'(LEN_KEYBOARD);
                        default: len = int'(LEN_WIDE);
                    endcase
                end
                else
                begin
                    len = $urandom_range(1, 12);
                end
                send_beat(KIND_BYTE, chan, 1'($urandom));
                mix_in(pull_pct, tick_pct);
                send_beat(KIND_BYTE, 8'(len), 1'($urandom));
                repeat ((len == 0) ? 256 : len)
                begin
                    mix_in(pull_pct, tick_pct);
                    send_beat(KIND_BYTE, 8'($urandom), 1'($urandom));
                end
                mix_in(pull_pct, tick_pct);
            end
        end
    endtask

    task automatic run_phase(input logic [7:0] hid_code, input logic [7:0] pipe_code,
                             input logic jiggle_on, input logic [15:0] period,
                             input int gap_max, input int hold_max, input int count,
                             input int pull_pct, input int tick_pct, input int long_pct);
        wait_drain();
        write_reg(REG_HID_CODE, {8'd0, hid_code});
        write_reg(REG_PIPE_CODE, {8'd0, pipe_code});
        write_reg(REG_JIGGLE_ENABLE, {15'd0, jiggle_on});
        write_reg(REG_JIGGLE_PERIOD, period);
        hid_chan = hid_code;
        pipe_chan = pipe_code;
        send_gap_max = gap_max;
        stall_max = hold_max;
        run_traffic(count, pull_pct, tick_pct, long_pct);
    endtask

    initial
    begin
        rst_n = 1'b0;
        item_valid = 1'b0;
        item = '0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        beats_sent = 0;
        send_gap_max = 10;
        stall_max = 10;
        hid_chan = HID_CODE_RST;
        pipe_chan = PIPE_CODE_RST;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // empty rings, idle tick with nothing pending
        send_beat(KIND_PULL_HID, 8'hFF, 1'b1);
        send_beat(KIND_PULL_PIPE, 8'h00, 1'b0);
        send_beat(KIND_TICK, 8'hA5, 1'b1);
        // mouse frame, padded to a full report, then resume once idle
        send_beat(KIND_BYTE, HID_CODE_RST, 1'b0);
        send_beat(KIND_BYTE, LEN_MOUSE, 1'b1);
        send_beat(KIND_BYTE, 8'h00, 1'b0);
        send_beat(KIND_BYTE, 8'hFF, 1'b1);
        send_beat(KIND_TICK, 8'h00, 1'b0);
        send_beat(KIND_TICK, 8'h00, 1'b1);
        send_beat(KIND_PULL_HID, 8'h5A, 1'b0);
        // four-byte frame takes the second report type
        send_beat(KIND_BYTE, HID_CODE_RST, 1'b0);
        send_beat(KIND_BYTE, LEN_WIDE, 1'b0);
        send_beat(KIND_BYTE, 8'h80, 1'b0);
        send_beat(KIND_BYTE, 8'h01, 1'b0);
        send_beat(KIND_BYTE, 8'h7F, 1'b0);
        send_beat(KIND_BYTE, 8'hFE, 1'b0);
        send_beat(KIND_PULL_HID, 8'h00, 1'b1);
        // pipe byte out, then pull the empty pipe ring
        send_beat(KIND_BYTE, PIPE_CODE_RST, 1'b0);
        send_beat(KIND_BYTE, 8'h01, 1'b0);
        send_beat(KIND_BYTE, 8'hA5, 1'b0);
        send_beat(KIND_PULL_PIPE, 8'hFF, 1'b1);
        send_beat(KIND_PULL_PIPE, 8'h00, 1'b0);
        // unknown channel is dropped
        send_beat(KIND_BYTE, 8'h00, 1'b0);
        send_beat(KIND_BYTE, 8'h01, 1'b0);
        send_beat(KIND_BYTE, 8'h55, 1'b0);

        run_phase(8'd1, 8'd2, 1'b1, 16'd3, 10, 10, 330, 15, 15, 2);
        run_phase(8'd0, 8'd255, 1'b1, 16'd1, 0, 10, 330, 12, 20, 1);
        run_phase(8'd255, 8'd255, 1'b0, 16'd2, 0, 0, 330, 3, 10, 3);
        run_phase(8'd7, 8'd0, 1'b1, 16'hFFFF, 10, 0, 330, 4, 10, 15);
        run_phase(8'd1, 8'd2, 1'b1, 16'd0, 10, 10, 330, 20, 15, 2);

        wait_drain();
        repeat (30) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
        begin
            $display("tlv_channel_demux_hid_queue_core: match");
        end
        else
        begin
            $display("tlv_channel_demux_hid_queue_core: mismatch");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
src/tlvd_pkg.sv
src/tlvd_ram.sv
src/tlv_channel_demux_hid_queue_core.sv
verif/tlvd_checker.sv
verif/testbench.sv
